[rtl/ricart_agrawala_mutex_node_core_macros.svh]
// assertion macros used by the node controller rtl
`ifndef RICART_AGRAWALA_MUTEX_NODE_CORE_MACROS_SVH
`define RICART_AGRAWALA_MUTEX_NODE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RAMA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rama check failed");
`define RAMA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("rama check failed");
`else
`define RAMA_ASSERT(name, prop)
`define RAMA_ASSERT_ALWAYS(name, prop)
`endif
`endif

[rtl/rama_pkg.sv]
// shared types and constants of the mutual exclusion node controller
package rama_pkg;

  localparam int unsigned DEF_MAX_NODES = 16;
  localparam int unsigned CLK_W         = 32;
  localparam int unsigned ID_W          = 4;
  localparam int unsigned NCNT_W        = 5;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 5;

  localparam logic [CLK_W-1:0] CLK_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;

  typedef enum logic [2:0] {
    CMD_IN_REQ   = 3'd0,
    CMD_IN_REPLY = 3'd1,
    CMD_IN_END   = 3'd2,
    CMD_LOC_REQ  = 3'd3,
    CMD_LOC_REL  = 3'd4,
    CMD_LOC_FIN  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ASKING = 2'd1,
    MODE_INCS   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BCAST = 2'd1,
    ST_REL   = 2'd2
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } dfifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } dfifo_stat_t;

endpackage

[rtl/ricart_agrawala_mutex_node_core.sv]
// ricart-agrawala node controller with a saturating lamport clock.
// a command is taken when start_i is high and busy_o is low. incoming messages,
// a refused local request, a release with nothing deferred and unknown commands
// give one result in the cycle after the command, busy_o stays low, so such
// commands run at one per cycle. a local request or finish broadcasts eff_n-1
// messages, eff_n being node_count held to 2..min(MAX_NODES,31), one result per
// cycle, busy_o high until the last one. a release gives one reply per deferred
// sender, one per cycle, paced by the read port of the deferred-sender memory.
// results are strobed by res_strobe_o for one cycle each and cannot be held off;
// last_o marks a command's final result. there is no clearing pass after reset.
`include "ricart_agrawala_mutex_node_core_macros.svh"
module ricart_agrawala_mutex_node_core import rama_pkg::*; #(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [2:0]            cmd_i,
  input  logic [CLK_W-1:0]      msg_time_i,
  input  logic [ID_W-1:0]       msg_sender_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  res_strobe_o,
  output logic                  send_valid_o,
  output logic [1:0]            send_kind_o,
  output logic [CLK_W-1:0]      send_time_o,
  output logic [ID_W-1:0]       send_dest_o,
  output logic                  in_section_o,
  output logic [3:0]            ends_seen_o,
  output logic                  last_o
);

  localparam int unsigned NMAX_EFF = (MAX_NODES < 31) ? MAX_NODES : 31;
  localparam logic [NCNT_W-1:0] N_CAP = NCNT_W'(NMAX_EFF);

  logic [ID_W-1:0]   node_id_q;
  logic [NCNT_W-1:0] node_count_q;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [CLK_W-1:0]  clk_q, clk_d;
  logic [CLK_W-1:0]  stamp_q, stamp_d;
  logic [3:0]        replies_q, replies_d;
  logic [3:0]        ends_q, ends_d;
  kind_e             kind_q, kind_d;
  logic [NCNT_W-1:0] idx_q, idx_d;

  logic              strobe_q, strobe_d;
  logic              sv_q, sv_d;
  kind_e             skind_q, skind_d;
  logic [CLK_W-1:0]  stime_q, stime_d;
  logic [ID_W-1:0]   sdest_q, sdest_d;
  logic              last_q, last_d;

  dfifo_ctl_t        fifo_ctl;
  dfifo_stat_t       fifo_stat;
  logic [ID_W-1:0]   fifo_rdata;

  logic [NCNT_W-1:0] eff_n;
  logic [NCNT_W-1:0] bc_dest;
  logic [CLK_W-1:0]  msg_max, clk_base, clk_new;
  logic [CLK_W:0]    clk_sum;
  logic [1:0]        clk_step;
  logic              prio, reply_ok;
  logic [3:0]        replies_inc, ends_inc;

  rama_dfifo #(
    .DEPTH (MAX_NODES)
  ) u_dfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fifo_ctl),
    .wdata_i (msg_sender_i),
    .rdata_o (fifo_rdata),
    .stat_o  (fifo_stat)
  );

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= '0;
      node_count_q <= NCNT_W'(2);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_ID:    node_id_q    <= cfg_data_i[ID_W-1:0];
        CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_n = (node_count_q < NCNT_W'(2)) ? NCNT_W'(2) :
                 (node_count_q > N_CAP)      ? N_CAP : node_count_q;

  // skip own id; an id beyond the node count leaves dests 0..n-2
  assign bc_dest = (idx_q < {1'b0, node_id_q}) ? idx_q : idx_q + NCNT_W'(1);

  assign prio     = (msg_time_i < stamp_q) ||
                    ((msg_time_i == stamp_q) && (msg_sender_i < node_id_q));
  assign reply_ok = (mode_q == MODE_IDLE) || ((mode_q == MODE_ASKING) && prio);

  assign replies_inc = (replies_q == 4'hF) ? replies_q : replies_q + 4'd1;
  assign ends_inc    = (ends_q == 4'hF) ? ends_q : ends_q + 4'd1;

  // merge then up to two saturating ticks as one add
  always_comb begin
    msg_max  = (msg_time_i > clk_q) ? msg_time_i : clk_q;
    clk_base = clk_q;
    clk_step = 2'd0;
    case (cmd_e'(cmd_i))
      CMD_IN_REQ: begin
        clk_base = msg_max;
        clk_step = reply_ok ? 2'd2 : 2'd1;
      end
      CMD_IN_REPLY, CMD_IN_END: begin
        clk_base = msg_max;
        clk_step = 2'd1;
      end
      CMD_LOC_REQ: clk_step = (mode_q == MODE_IDLE) ? 2'd1 : 2'd0;
      CMD_LOC_REL: clk_step = (mode_q == MODE_INCS) ? 2'd1 : 2'd0;
      CMD_LOC_FIN: clk_step = 2'd1;
      default: ;
    endcase
  end

  assign clk_sum = {1'b0, clk_base} + (CLK_W + 1)'(clk_step);
  assign clk_new = clk_sum[CLK_W] ? CLK_MAX : clk_sum[CLK_W-1:0];

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    clk_d     = clk_q;
    stamp_d   = stamp_q;
    replies_d = replies_q;
    ends_d    = ends_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    strobe_d  = 1'b0;
    sv_d      = sv_q;
    skind_d   = skind_q;
    stime_d   = stime_q;
    sdest_d   = sdest_q;
    last_d    = last_q;
    fifo_ctl  = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          clk_d    = clk_new;
          strobe_d = 1'b1;
          sv_d     = 1'b0;
          skind_d  = KIND_REQ;
          stime_d  = '0;
          sdest_d  = '0;
          last_d   = 1'b1;
          case (cmd_e'(cmd_i))
            CMD_IN_REQ: begin
              if (reply_ok) begin
                sv_d    = 1'b1;
                skind_d = KIND_REPLY;
                stime_d = clk_new;
                sdest_d = msg_sender_i;
              end else begin
                fifo_ctl.push = !fifo_stat.full;
              end
            end
            CMD_IN_REPLY: begin
              replies_d = replies_inc;
              if ((mode_q == MODE_ASKING) && ({1'b0, replies_inc} == eff_n - NCNT_W'(1))) begin
                mode_d = MODE_INCS;
              end
            end
            CMD_IN_END: ends_d = ends_inc;
            CMD_LOC_REQ: begin
              if (mode_q == MODE_IDLE) begin
                stamp_d   = clk_new;
                mode_d    = MODE_ASKING;
                replies_d = '0;
                kind_d    = KIND_REQ;
                idx_d     = '0;
                state_d   = ST_BCAST;
                strobe_d  = 1'b0;
              end
            end
            CMD_LOC_REL: begin
              if (mode_q == MODE_INCS) begin
                mode_d = MODE_IDLE;
                if (!fifo_stat.empty) begin
                  state_d  = ST_REL;
                  strobe_d = 1'b0;
                end
              end
            end
            CMD_LOC_FIN: begin
              kind_d   = KIND_END;
              idx_d    = '0;
              state_d  = ST_BCAST;
              strobe_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_BCAST: begin
        strobe_d = 1'b1;
        sv_d     = 1'b1;
        skind_d  = kind_q;
        stime_d  = clk_q;
        sdest_d  = bc_dest[ID_W-1:0];
        last_d   = (idx_q == eff_n - NCNT_W'(2));
        idx_d    = idx_q + NCNT_W'(1);
        if (idx_q == eff_n - NCNT_W'(2)) begin
          state_d = ST_IDLE;
        end
      end
      ST_REL: begin
        strobe_d     = 1'b1;
        sv_d         = 1'b1;
        skind_d      = KIND_REPLY;
        stime_d      = clk_q;
        sdest_d      = fifo_rdata;
        last_d       = fifo_stat.one_left;
        fifo_ctl.pop = 1'b1;
        if (fifo_stat.one_left) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_IDLE;
      clk_q     <= '0;
      stamp_q   <= '0;
      replies_q <= '0;
      ends_q    <= '0;
      kind_q    <= KIND_REQ;
      idx_q     <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      clk_q     <= clk_d;
      stamp_q   <= stamp_d;
      replies_q <= replies_d;
      ends_q    <= ends_d;
      kind_q    <= kind_d;
      idx_q     <= idx_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sv_q    <= sv_d;
    skind_q <= skind_d;
    stime_q <= stime_d;
    sdest_q <= sdest_d;
    last_q  <= last_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign send_valid_o = sv_q;
  assign send_kind_o  = skind_q;
  assign send_time_o  = stime_q;
  assign send_dest_o  = sdest_q;
  assign in_section_o = (mode_q == MODE_INCS);
  assign ends_seen_o  = ends_q;
  assign last_o       = last_q;

  `RAMA_ASSERT(a_rise_no_strobe, $rose(busy_o) |-> !res_strobe_o)
  `RAMA_ASSERT(a_bcast_strobes, (state_q == ST_BCAST) |=> res_strobe_o)
  `RAMA_ASSERT(a_last_frees, (res_strobe_o && last_o) |-> !busy_o)
  `RAMA_ASSERT(a_rel_nonempty, (state_q == ST_REL) |-> !fifo_stat.empty)
  `RAMA_ASSERT_ALWAYS(a_push_pop_apart, !(fifo_ctl.push && fifo_ctl.pop))

endmodule

[rtl/rama_dfifo.sv]
// deferred-sender fifo held in a synchronous memory with head, tail and fill
module rama_dfifo import rama_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_NODES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dfifo_ctl_t        ctl_i,
  input  logic [ID_W-1:0]   wdata_i,
  output logic [ID_W-1:0]   rdata_o,
  output dfifo_stat_t       stat_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] FULL_FILL = AW'(DEPTH - 1);

  logic [ID_W-1:0] mem_q [DEPTH];
  logic [ID_W-1:0] rd_q;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   tail_q, tail_d;
  logic [AW-1:0]   fill_q, fill_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (ctl_i.pop) begin
      head_d = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
      fill_d = fill_q - AW'(1);
    end
    if (ctl_i.push) begin
      tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
      fill_d = fill_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // read follows the next head, so the entry is ready the cycle it is popped;
  // pushes and pops belong to different items and never overlap
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= wdata_i;
    end
    rd_q <= mem_q[head_d];
  end

  assign rdata_o         = rd_q;
  assign stat_o.empty    = (fill_q == '0);
  assign stat_o.full     = (fill_q == FULL_FILL);
  assign stat_o.one_left = (fill_q == AW'(1));

endmodule

[dv/ricart_agrawala_mutex_node_core_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench of the ricart-agrawala mutex node controller
module ricart_agrawala_mutex_node_core_tb import rama_pkg::*;;

  localparam int QUIET_LIMIT = 500;
  localparam int SETTLE      = 4;
  localparam int FIFO_SLOTS  = DEF_MAX_NODES - 1;

  typedef struct {
    logic             send_valid;
    kind_e            kind;
    logic [CLK_W-1:0] stamp;
    logic [ID_W-1:0]  dest;
    logic             in_sec;
    logic [3:0]       ends;
    logic             last;
  } node_msg_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [2:0]            cmd_i = '0;
  logic [CLK_W-1:0]      msg_time_i = '0;
  logic [ID_W-1:0]       msg_sender_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  res_strobe_o;
  logic                  send_valid_o;
  logic [1:0]            send_kind_o;
  logic [CLK_W-1:0]      send_time_o;
  logic [ID_W-1:0]       send_dest_o;
  logic                  in_section_o;
  logic [3:0]            ends_seen_o;
  logic                  last_o;

  // node state as predicted
  logic [CLK_W-1:0]  lam_clk = '0;
  logic [CLK_W-1:0]  req_stamp = '0;
  mode_e             node_mode = MODE_IDLE;
  logic [3:0]        reply_cnt = '0;
  logic [3:0]        end_cnt = '0;
  logic [ID_W-1:0]   defer_mem [DEF_MAX_NODES];
  logic [3:0]        defer_head = '0;
  logic [4:0]        defer_fill = '0;
  logic [ID_W-1:0]   own_id = '0;
  logic [NCNT_W-1:0] nodes_cfg = 5'd2;

  node_msg_t step_msgs[$];
  node_msg_t msgs_due[$];
  int        err_count = 0;
  int        items_sent = 0;
  int        idle_pct = 0;
  int        quiet_cycles = 0;

  ricart_agrawala_mutex_node_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .msg_time_i   (msg_time_i),
    .msg_sender_i (msg_sender_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .send_valid_o (send_valid_o),
    .send_kind_o  (send_kind_o),
    .send_time_o  (send_time_o),
    .send_dest_o  (send_dest_o),
    .in_section_o (in_section_o),
    .ends_seen_o  (ends_seen_o),
    .last_o       (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [CLK_W-1:0] sat_inc(input logic [CLK_W-1:0] x);
    return (x == CLK_MAX) ? x : x + 1'b1;
  endfunction

  function automatic int eff_nodes();
    int n;
    n = int'(nodes_cfg);
    if (n < 2) n = 2;
    if (n > DEF_MAX_NODES) n = DEF_MAX_NODES;
    return n;
  endfunction

  function automatic void add_msg(input kind_e kind, input logic [ID_W-1:0] dest);
    node_msg_t m;
    m.send_valid = 1'b1;
    m.kind       = kind;
    m.stamp      = lam_clk;
    m.dest       = dest;
    m.in_sec     = 1'b0;
    m.ends       = '0;
    m.last       = 1'b0;
    step_msgs.push_back(m);
  endfunction

  // own id is skipped; an id past the node range leaves nodes 0..n-2
  function automatic void add_broadcast(input kind_e kind);
    int n;
    int k;
    n = eff_nodes();
    k = 0;
    for (int i = 0; i < n && k < n - 1; i++) begin
      if (i != own_id) begin
        add_msg(kind, ID_W'(i));
        k++;
      end
    end
  endfunction

  task automatic node_step(input logic [2:0] c, input logic [CLK_W-1:0] t,
                           input logic [ID_W-1:0] s);
    node_msg_t m;
    logic      prio;
    step_msgs.delete();
    if (c == CMD_IN_REQ || c == CMD_IN_REPLY || c == CMD_IN_END)
      lam_clk = sat_inc((t > lam_clk) ? t : lam_clk);
    case (c)
      CMD_IN_REQ: begin
        prio = (t < req_stamp) || (t == req_stamp && s < own_id);
        if (node_mode == MODE_IDLE || (node_mode == MODE_ASKING && prio)) begin
          lam_clk = sat_inc(lam_clk);
          add_msg(KIND_REPLY, s);
        end else if (defer_fill < FIFO_SLOTS) begin
          defer_mem[defer_head + defer_fill[3:0]] = s;
          defer_fill++;
        end
      end
      CMD_IN_REPLY: begin
        if (reply_cnt != 4'd15) reply_cnt++;
        if (node_mode == MODE_ASKING && reply_cnt == eff_nodes() - 1) node_mode = MODE_INCS;
      end
      CMD_IN_END: begin
        if (end_cnt != 4'd15) end_cnt++;
      end
      CMD_LOC_REQ: begin
        if (node_mode == MODE_IDLE) begin
          lam_clk   = sat_inc(lam_clk);
          req_stamp = lam_clk;
          node_mode = MODE_ASKING;
          reply_cnt = '0;
          add_broadcast(KIND_REQ);
        end
      end
      CMD_LOC_REL: begin
        if (node_mode == MODE_INCS) begin
          lam_clk = sat_inc(lam_clk);
          while (defer_fill != 0) begin
            add_msg(KIND_REPLY, defer_mem[defer_head]);
            defer_head++;
            defer_fill--;
          end
          node_mode = MODE_IDLE;
        end
      end
      CMD_LOC_FIN: begin
        lam_clk = sat_inc(lam_clk);
        add_broadcast(KIND_END);
      end
      default: ;
    endcase
    // status-only beat carries zero message fields
    if (step_msgs.size() == 0) begin
      m.send_valid = 1'b0;
      m.kind       = KIND_REQ;
      m.stamp      = '0;
      m.dest       = '0;
      step_msgs.push_back(m);
    end
    foreach (step_msgs[i]) begin
      m        = step_msgs[i];
      m.in_sec = (node_mode == MODE_INCS);
      m.ends   = end_cnt;
      m.last   = (i == step_msgs.size() - 1);
      msgs_due.push_back(m);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    node_msg_t m;
    if (rst_ni && res_strobe_o) begin
      if (msgs_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        m = msgs_due.pop_front();
        check_field("send_valid", 32'(send_valid_o), 32'(m.send_valid));
        check_field("send_kind", 32'(send_kind_o), 32'(m.kind));
        check_field("send_time", send_time_o, m.stamp);
        check_field("send_dest", 32'(send_dest_o), 32'(m.dest));
        check_field("in_section", 32'(in_section_o), 32'(m.in_sec));
        check_field("ends_seen", 32'(ends_seen_o), 32'(m.ends));
        check_field("last", 32'(last_o), 32'(m.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ricart_agrawala_mutex_node_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [2:0] c, input logic [CLK_W-1:0] t,
                          input logic [ID_W-1:0] s);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i        <= c;
    msg_time_i   <= t;
    msg_sender_i <= s;
    do @(posedge clk_i); while (busy_o);
    node_step(c, t, s);
    items_sent++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (msgs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_NODE_ID) own_id = data[ID_W-1:0];
    else if (idx == CFG_NODE_COUNT) nodes_cfg = data;
  endtask

  task automatic set_nodes(input logic [ID_W-1:0] id, input logic [NCNT_W-1:0] cnt);
    write_reg(CFG_NODE_ID, {1'b0, id});
    write_reg(CFG_NODE_COUNT, cnt);
  endtask

  // timestamps around the pending request and the clock, with a few wild ones
  function automatic logic [CLK_W-1:0] pick_time();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return req_stamp;
      2: return (req_stamp == 0) ? req_stamp : req_stamp - 1'b1;
      3: return req_stamp + 1'b1;
      4: return $urandom_range(0, 15);
      default: return lam_clk + $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_sender();
    return ID_W'($urandom_range(0, 15));
  endfunction

  task automatic send_noise();
    send_cmd(3'($urandom_range(0, 7)), pick_time(), pick_sender());
  endtask

  task automatic test_directed();
    logic [CLK_W-1:0] stamp0;
    set_nodes(4'd1, 5'd4);
    send_cmd(3'd6, '0, '0);
    send_cmd(3'd7, CLK_MAX, 4'd15);
    send_cmd(CMD_IN_END, '0, '0);
    send_cmd(CMD_IN_REPLY, 32'd5, 4'd2);
    send_cmd(CMD_IN_REQ, 32'd3, 4'd3);
    send_cmd(CMD_LOC_REL, '0, '0);
    send_cmd(CMD_LOC_REQ, '0, '0);
    stamp0 = req_stamp;
    send_cmd(CMD_LOC_REQ, '0, '0);
    send_cmd(CMD_IN_REQ, stamp0 - 1'b1, 4'd3);
    send_cmd(CMD_IN_REQ, stamp0, 4'd0);
    send_cmd(CMD_IN_REQ, stamp0, 4'd2);
    send_cmd(CMD_IN_REQ, stamp0 + 5, 4'd3);
    repeat (3) send_cmd(CMD_IN_REPLY, '0, 4'd2);
    send_cmd(CMD_IN_REQ, '0, 4'd0);
    send_cmd(CMD_LOC_FIN, '0, '0);
    send_cmd(CMD_LOC_REL, '0, '0);
    send_cmd(CMD_LOC_REL, '0, '0);
  endtask

  task automatic test_own_id_outside();
    set_nodes(4'd15, 5'd3);
    send_cmd(CMD_LOC_REQ, '0, '0);
    send_cmd(CMD_IN_REQ, '0, 4'd9);
    while (node_mode == MODE_ASKING) send_cmd(CMD_IN_REPLY, pick_time(), 4'd1);
    send_cmd(CMD_LOC_FIN, '0, '0);
    send_cmd(CMD_LOC_REL, '0, '0);
  endtask

  // more requests in the section than the deferred list can hold
  task automatic test_fifo_full();
    set_nodes(4'd15, 5'd16);
    send_cmd(CMD_LOC_REQ, '0, '0);
    while (node_mode == MODE_ASKING) send_cmd(CMD_IN_REPLY, pick_time(), pick_sender());
    repeat (FIFO_SLOTS + 2) send_cmd(CMD_IN_REQ, pick_time(), pick_sender());
    send_cmd(CMD_LOC_REL, '0, '0);
  endtask

  task automatic test_counter_saturation();
    repeat (16) begin
      send_cmd(CMD_IN_END, pick_time(), pick_sender());
      send_cmd(CMD_IN_REPLY, pick_time(), pick_sender());
    end
  endtask

  task automatic run_round();
    int r;
    repeat ($urandom_range(0, 2)) send_cmd(CMD_IN_REQ, pick_time(), pick_sender());
    send_cmd(CMD_LOC_REQ, $urandom, pick_sender());
    while (node_mode == MODE_ASKING) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_cmd(CMD_IN_REPLY, pick_time(), pick_sender());
      else if (r < 85) send_cmd(CMD_IN_REQ, pick_time(), pick_sender());
      else send_noise();
    end
    repeat ($urandom_range(0, 3)) send_cmd(CMD_IN_REQ, pick_time(), pick_sender());
    if ($urandom_range(0, 3) == 0) send_cmd(CMD_LOC_FIN, $urandom, pick_sender());
    send_cmd(CMD_LOC_REL, $urandom, pick_sender());
  endtask

  task automatic test_random_rounds();
    int first;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin set_nodes(4'd0, 5'd2); idle_pct = 0; end
        1: begin set_nodes(4'd6, 5'd9); idle_pct = 84; end
        2: begin
          set_nodes(pick_sender(), NCNT_W'($urandom_range(2, 16)));
          idle_pct = 24;
        end
        3: begin set_nodes(4'd15, 5'd16); idle_pct = 84; end
        4: begin set_nodes(4'd3, 5'd5); idle_pct = 0; end
        default: begin
          set_nodes(pick_sender(), NCNT_W'($urandom_range(2, 16)));
          idle_pct = 24;
        end
      endcase
      first = items_sent;
      while (items_sent - first < 20) begin
        if ($urandom_range(0, 3) == 0) send_noise();
        run_round();
        // hold off new commands until every beat is back
        if ($urandom_range(0, 2) == 0 || ph == 4) wait_drained();
      end
    end
    idle_pct = 0;
  endtask

  task automatic test_clock_saturation();
    set_nodes(4'd7, 5'd4);
    send_cmd(CMD_IN_REQ, CLK_MAX, 4'd2);
    send_cmd(CMD_LOC_REQ, '0, '0);
    send_cmd(CMD_IN_REQ, CLK_MAX, 4'd0);
    while (node_mode == MODE_ASKING) send_cmd(CMD_IN_REPLY, CLK_MAX, 4'd1);
    send_cmd(CMD_LOC_REL, '0, '0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_own_id_outside();
    test_fifo_full();
    test_counter_saturation();
    test_random_rounds();
    test_clock_saturation();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) $display("ricart_agrawala_mutex_node_core_tb OK");
    else $display("ricart_agrawala_mutex_node_core_tb NOT OK");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rama_pkg.sv
rtl/rama_dfifo.sv
rtl/ricart_agrawala_mutex_node_core.sv
dv/ricart_agrawala_mutex_node_core_tb.sv
